// ===== src/quaternion_to_euler_assert.svh =====
// assertion macros shared by the quaternion to euler checker
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// checked only while out of reset
`define Q2E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/q2e_pkg.sv =====
// shared constants, types and the cordic arctangent table for the quaternion to euler block
`default_nettype none

package q2e_pkg;

	localparam int QUAT_BITS     = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// internal fixed point: 28 fraction bits
	localparam int WORK_FRAC = 28;
	localparam int PROD_W    = 32;
	localparam int WORK_W    = 34;
	localparam int CORDIC_W  = WORK_W + 3;
	localparam int ACC_W     = 32;
	localparam int ROOT_W    = WORK_FRAC + 1;
	localparam int RAD_W     = 2 * WORK_FRAC + 3;
	localparam int SQ_W      = 2 * WORK_FRAC;

	localparam int TERMS_LAT = 2;
	// square, radicand, one stage per root bit
	localparam int ISQ_LAT   = ROOT_W + 2;

	localparam logic signed [WORK_W-1:0] WORK_ONE = WORK_W'(64'sd1 <<< WORK_FRAC);

	localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ACC_W-1:0] QUARTER_POS  = 32'h4000_0000;
	localparam logic [ACC_W-1:0] QUARTER_NEG  = 32'hC000_0000;

	localparam logic [ACC_W-1:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic signed [WORK_W-1:0] rs;
		logic signed [WORK_W-1:0] rc;
		logic signed [WORK_W-1:0] ys;
		logic signed [WORK_W-1:0] yc;
		logic signed [WORK_W-1:0] ps;
	} terms_t;

endpackage

`default_nettype wire

// ===== src/quaternion_to_euler.sv =====
// top level: quaternion in, zyx euler binary angles out
//
// channel  signals                                           dir
// quat     quat_valid quat_ready quat_w quat_x quat_y quat_z  in
// euler    euler_valid euler_ready roll_angle pitch_angle
//          yaw_angle pitch_saturated                          out
//
// one item per cycle unless the output stalls; the pipeline is 2 product/sum stages,
// 31 square root stages, 1 + CORDIC_STAGES cordic stages and 1 output register
// the square root pipeline sets most of the depth; roll and yaw wait alongside it
// the whole pipeline holds when the output register is full and not taken
// reset clears only the valid bits
`default_nettype none

module quaternion_to_euler #(
	parameter int QUAT_BITS     = q2e_pkg::QUAT_BITS,
	parameter int ANGLE_BITS    = q2e_pkg::ANGLE_BITS,
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         quat_valid,
	output logic                              quat_ready,
	input  wire logic signed [QUAT_BITS-1:0]  quat_w,
	input  wire logic signed [QUAT_BITS-1:0]  quat_x,
	input  wire logic signed [QUAT_BITS-1:0]  quat_y,
	input  wire logic signed [QUAT_BITS-1:0]  quat_z,
	output logic                              euler_valid,
	input  wire logic                         euler_ready,
	output logic signed [ANGLE_BITS-1:0]      roll_angle,
	output logic signed [ANGLE_BITS-1:0]      pitch_angle,
	output logic signed [ANGLE_BITS-1:0]      yaw_angle,
	output logic                              pitch_saturated
);

	localparam int WW     = q2e_pkg::WORK_W;
	localparam int AW     = q2e_pkg::ACC_W;
	localparam int CLAT   = CORDIC_STAGES + 1;
	localparam int LAT    = q2e_pkg::TERMS_LAT + q2e_pkg::ISQ_LAT + CLAT + 1;
	localparam int RND_SH = AW - ANGLE_BITS;
	localparam int SIDE_W = 5 * WW + 2;

	logic en;
	assign en         = !euler_valid || euler_ready;
	assign quat_ready = en;

	logic [LAT-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], quat_valid};
		end
	end

	assign euler_valid = valid_q[LAT-1];

	q2e_pkg::terms_t terms;

	q2e_terms #(
		.QUAT_BITS(QUAT_BITS)
	) u_terms (
		.clk      (clk),
		.en       (en),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.terms_s2 (terms)
	);

	logic sat, sat_neg;
	assign sat     = (terms.ps >= q2e_pkg::WORK_ONE) || (terms.ps <= -q2e_pkg::WORK_ONE);
	assign sat_neg = terms.ps[WW-1];

	logic [q2e_pkg::ROOT_W-1:0] root;

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.ps   (terms.ps),
		.root (root)
	);

	q2e_pkg::terms_t terms_d;
	logic            sat_d, sat_neg_d;

	q2e_delay #(
		.W(SIDE_W),
		.D(q2e_pkg::ISQ_LAT)
	) u_side (
		.clk (clk),
		.en  (en),
		.d   ({terms, sat, sat_neg}),
		.q   ({terms_d, sat_d, sat_neg_d})
	);

	logic sat_c, sat_neg_c;

	q2e_delay #(
		.W(2),
		.D(CLAT)
	) u_flag (
		.clk (clk),
		.en  (en),
		.d   ({sat_d, sat_neg_d}),
		.q   ({sat_c, sat_neg_c})
	);

	logic [AW-1:0] roll_ph, pitch_ph, yaw_ph;

	q2e_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (terms_d.rs),
		.x_in  (terms_d.rc),
		.phase (roll_ph)
	);

	q2e_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (terms_d.ps),
		.x_in  (WW'(root)),
		.phase (pitch_ph)
	);

	q2e_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (terms_d.ys),
		.x_in  (terms_d.yc),
		.phase (yaw_ph)
	);

	// round to the output step by adding half a step, then truncate
	function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [AW-1:0] ph);
		logic [AW:0] s;
		s = {1'b0, ph} + (((AW+1)'(1) << RND_SH) >> 1);
		return s[RND_SH +: ANGLE_BITS];
	endfunction

	logic [AW-1:0] pitch_sel;
	assign pitch_sel = !sat_c    ? pitch_ph :
	                   sat_neg_c ? q2e_pkg::QUARTER_NEG : q2e_pkg::QUARTER_POS;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_angle      <= to_angle(roll_ph);
			pitch_angle     <= to_angle(pitch_sel);
			yaw_angle       <= to_angle(yaw_ph);
			pitch_saturated <= sat_c;
		end
	end

endmodule

`default_nettype wire

// ===== src/q2e_delay.sv =====
// enabled shift line that carries side data alongside a pipeline
`default_nettype none

module q2e_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] pipe_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				pipe_q[i] <= pipe_q[i-1];
			end
		end
	end

	assign q = pipe_q[D-1];

endmodule

`default_nettype wire

// ===== src/q2e_terms.sv =====
// component products and the five sum-of-products terms, two register stages
`default_nettype none

module q2e_terms #(
	parameter int QUAT_BITS = q2e_pkg::QUAT_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic signed [QUAT_BITS-1:0] quat_w,
	input  wire logic signed [QUAT_BITS-1:0] quat_x,
	input  wire logic signed [QUAT_BITS-1:0] quat_y,
	input  wire logic signed [QUAT_BITS-1:0] quat_z,
	output q2e_pkg::terms_t                  terms_s2
);

	localparam int MUL_W   = 2 * QUAT_BITS;
	localparam int SHIFT_R = 2 * (QUAT_BITS - 2) - q2e_pkg::WORK_FRAC;
	localparam int SR      = (SHIFT_R > 0) ? SHIFT_R : 0;
	localparam int SL      = (SHIFT_R < 0) ? -SHIFT_R : 0;
	localparam int WIDE_W  = MUL_W + q2e_pkg::WORK_FRAC;
	localparam int PW      = q2e_pkg::PROD_W;
	localparam int WW      = q2e_pkg::WORK_W;

	// bring a raw product to the working fraction, floor on right shift
	function automatic logic signed [PW-1:0] scale(input logic signed [MUL_W-1:0] p);
		logic signed [WIDE_W-1:0] e;
		e = WIDE_W'(p);
		e = (e <<< SL) >>> SR;
		return e[PW-1:0];
	endfunction

	logic signed [MUL_W-1:0] w_e, x_e, y_e, z_e;
	assign w_e = MUL_W'(quat_w);
	assign x_e = MUL_W'(quat_x);
	assign y_e = MUL_W'(quat_y);
	assign z_e = MUL_W'(quat_z);

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= scale(w_e * x_e);
			yz_s1 <= scale(y_e * z_e);
			xx_s1 <= scale(x_e * x_e);
			yy_s1 <= scale(y_e * y_e);
			wz_s1 <= scale(w_e * z_e);
			xy_s1 <= scale(x_e * y_e);
			zz_s1 <= scale(z_e * z_e);
			wy_s1 <= scale(w_e * y_e);
			zx_s1 <= scale(z_e * x_e);
		end
	end

	q2e_pkg::terms_t terms_d;

	always_comb begin
		terms_d.rs = (WW'(wx_s1) + WW'(yz_s1)) <<< 1;
		terms_d.rc = q2e_pkg::WORK_ONE - ((WW'(xx_s1) + WW'(yy_s1)) <<< 1);
		terms_d.ys = (WW'(wz_s1) + WW'(xy_s1)) <<< 1;
		terms_d.yc = q2e_pkg::WORK_ONE - ((WW'(yy_s1) + WW'(zz_s1)) <<< 1);
		terms_d.ps = (WW'(wy_s1) - WW'(zx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s2 <= terms_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/q2e_isqrt.sv =====
// pipelined floor square root of one minus the pitch sine squared, one root bit per stage
`default_nettype none

module q2e_isqrt (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [q2e_pkg::WORK_W-1:0]    ps,
	output logic             [q2e_pkg::ROOT_W-1:0]    root
);

	localparam int FRAC  = q2e_pkg::WORK_FRAC;
	localparam int RW    = q2e_pkg::ROOT_W;
	localparam int RADW  = q2e_pkg::RAD_W;
	localparam int SQW   = q2e_pkg::SQ_W;

	logic signed [q2e_pkg::WORK_W-1:0] mag;
	logic [FRAC-1:0]                   mag_n;

	// magnitude is below one whenever the root is used
	assign mag   = ps[q2e_pkg::WORK_W-1] ? -ps : ps;
	assign mag_n = mag[FRAC-1:0];

	logic [SQW-1:0]  sq_s1;
	logic [RADW-1:0] rad_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= SQW'(mag_n) * SQW'(mag_n);
			rad_s2 <= (RADW'(1) << SQW) - RADW'(sq_s1);
		end
	end

	logic [RADW-1:0] rem_q  [RW];
	logic [RW-1:0]   root_q [RW];

	for (genvar j = 0; j < RW; j++) begin : g_bit
		localparam int K = RW - 1 - j;
		logic [RADW-1:0] rem_in;
		logic [RW-1:0]   root_in;
		logic [RADW-1:0] trial;

		if (j == 0) begin : g_first
			assign rem_in  = rad_s2;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
		end

		assign trial = (RADW'(root_in) << (K + 1)) + (RADW'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[j]  <= rem_in - trial;
					root_q[j] <= root_in | (RW'(1) << K);
				end else begin
					rem_q[j]  <= rem_in;
					root_q[j] <= root_in;
				end
			end
		end
	end

	assign root = root_q[RW-1];

endmodule

`default_nettype wire

// ===== src/q2e_cordic.sv =====
// pipelined cordic vectoring atan2, phase in 32-bit turns
`default_nettype none

module q2e_cordic #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [q2e_pkg::WORK_W-1:0]   y_in,
	input  wire logic signed [q2e_pkg::WORK_W-1:0]   x_in,
	output logic             [q2e_pkg::ACC_W-1:0]    phase
);

	localparam int CW = q2e_pkg::CORDIC_W;
	localparam int AW = q2e_pkg::ACC_W;

	logic signed [CW-1:0] x_q    [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_q    [CORDIC_STAGES+1];
	logic        [AW-1:0] acc_q  [CORDIC_STAGES+1];
	logic                 zero_q [CORDIC_STAGES+1];

	logic signed [CW-1:0] x_e, y_e;
	assign x_e = CW'(x_in);
	assign y_e = CW'(y_in);

	// fold the left half plane onto the right with a half turn preset
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (x_in == '0) && (y_in == '0);
			if (x_e < 0) begin
				x_q[0]   <= -x_e;
				y_q[0]   <= -y_e;
				acc_q[0] <= q2e_pkg::HALF_TURN;
			end else begin
				x_q[0]   <= x_e;
				y_q[0]   <= y_e;
				acc_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [CW-1:0] dx, dy;
		assign dx = y_q[i] >>> i;
		assign dy = x_q[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (y_q[i] >= 0) begin
					x_q[i+1]   <= x_q[i] + dx;
					y_q[i+1]   <= y_q[i] - dy;
					acc_q[i+1] <= acc_q[i] + q2e_pkg::ATAN_TURNS[i];
				end else begin
					x_q[i+1]   <= x_q[i] - dx;
					y_q[i+1]   <= y_q[i] + dy;
					acc_q[i+1] <= acc_q[i] - q2e_pkg::ATAN_TURNS[i];
				end
			end
		end
	end

	assign phase = zero_q[CORDIC_STAGES] ? '0 : acc_q[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== src/q2e_checker.sv =====
// port-level checker for the quaternion to euler block and its bind
`default_nettype none

`include "quaternion_to_euler_assert.svh"

module q2e_checker #(
	parameter int QUAT_BITS  = q2e_pkg::QUAT_BITS,
	parameter int ANGLE_BITS = q2e_pkg::ANGLE_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  quat_valid,
	input wire logic                  quat_ready,
	input wire logic [QUAT_BITS-1:0]  quat_w,
	input wire logic                  euler_valid,
	input wire logic                  euler_ready,
	input wire logic [ANGLE_BITS-1:0] roll_angle,
	input wire logic [ANGLE_BITS-1:0] pitch_angle,
	input wire logic [ANGLE_BITS-1:0] yaw_angle,
	input wire logic                  pitch_saturated
);

	localparam logic [ANGLE_BITS-1:0] QUARTER     = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] NEG_QUARTER = -QUARTER;

	logic in_seen;
	assign in_seen = quat_valid && (quat_w == quat_w);

	`Q2E_ASSERT_ALWAYS(a_no_valid_in_reset, !arst_n |-> !euler_valid, "output valid during reset")

	`Q2E_ASSERT(a_ready_follows_out, in_seen |-> (quat_ready == (!euler_valid || euler_ready)), "input ready does not follow output stall")

	`Q2E_ASSERT(a_sat_quarter, (euler_valid && pitch_saturated) |-> (pitch_angle == QUARTER || pitch_angle == NEG_QUARTER), "saturated pitch is not a quarter turn")

	`Q2E_ASSERT(a_out_hold, (euler_valid && !euler_ready) |=> (euler_valid && $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_saturated)), "stalled output item changed")

endmodule

bind quaternion_to_euler q2e_checker #(
	.QUAT_BITS  (QUAT_BITS),
	.ANGLE_BITS (ANGLE_BITS)
) u_q2e_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.quat_valid      (quat_valid),
	.quat_ready      (quat_ready),
	.quat_w          (quat_w),
	.euler_valid     (euler_valid),
	.euler_ready     (euler_ready),
	.roll_angle      (roll_angle),
	.pitch_angle     (pitch_angle),
	.yaw_angle       (yaw_angle),
	.pitch_saturated (pitch_saturated)
);

`default_nettype wire
